@@ rtl/ssol_pkg.sv @@
// Shared types and constants for the solid span occlusion list.
package ssol_pkg;

    localparam int MAX_SPANS_DEF    = 32;
    localparam int COLUMN_BITS_DEF  = 14;
    localparam int MAX_RESULTS      = 32;
    localparam int RES_CNT_BITS     = 6;
    localparam int WIDTH_CAP        = 4096;
    localparam int VIEW_WIDTH_RESET = 320;
    localparam int SPAN_BITS        = 14;
    localparam int FRAG_BITS        = 12;
    localparam int VW_BITS          = 13;
    localparam int APB_ADDR_BITS    = 3;
    localparam int APB_DATA_BITS    = 32;
    localparam int S_TDATA_BITS     = 32;
    localparam int M_TDATA_BITS     = 24;

    localparam logic REG_VIEW_WIDTH = 1'b0;

    localparam logic MODE_CLEAR  = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CLR_LO,
        ST_CLR_HI,
        ST_PASS,
        ST_TAIL,
        ST_COMMIT,
        ST_FLUSH
    } ctrl_state_t;

    typedef enum logic [1:0] {
        PH_SEEK,
        PH_MERGE,
        PH_COPY
    } merge_phase_t;

    typedef struct packed {
        logic load;
        logic clr_lo;
        logic clr_hi;
        logic prime;
        logic step;
        logic tail;
        logic commit;
        logic flush;
    } dp_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic ignore;
        logic go;
        logic pass_end;
        logic need_tail;
        logic flush_ok;
    } dp_stat_t;

endpackage

@@ rtl/ssol_ram.sv @@
// Generic simple dual-port RAM, one write port, one registered read port.
module ssol_ram import ssol_pkg::*; #(
    parameter int WIDTH = 2 * COLUMN_BITS_DEF,
    parameter int DEPTH = 2 * MAX_SPANS_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/ssol_ctrl.sv @@
// Sequencer for clear, merge pass, commit and fragment flush.
module ssol_ctrl import ssol_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR_LO;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                if (stat.is_clear)    state_next = ST_CLR_LO;
                else if (stat.ignore) state_next = ST_IDLE;
                else                  state_next = ST_PASS;
            end
            ST_CLR_LO: state_next = ST_CLR_HI;
            ST_CLR_HI: state_next = ST_IDLE;
            ST_PASS: begin
                if (stat.pass_end) state_next = stat.need_tail ? ST_TAIL : ST_COMMIT;
            end
            ST_TAIL: begin
                if (stat.go) state_next = ST_COMMIT;
            end
            ST_COMMIT: state_next = ST_FLUSH;
            ST_FLUSH: begin
                if (stat.flush_ok) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_DISPATCH: cmd.prime  = !stat.is_clear && !stat.ignore;
            ST_CLR_LO:   cmd.clr_lo = 1'b1;
            ST_CLR_HI:   cmd.clr_hi = 1'b1;
            ST_PASS:     cmd.step   = 1'b1;
            ST_TAIL:     cmd.tail   = 1'b1;
            ST_COMMIT:   cmd.commit = 1'b1;
            ST_FLUSH:    cmd.flush  = 1'b1;
            default:     cmd        = '0;
        endcase
    end

endmodule

@@ rtl/ssol_dp.sv @@
// Span list datapath: ping-pong list memory, merge step, clamp and fragment output.
module ssol_dp import ssol_pkg::*; #(
    parameter int MAX_SPANS   = MAX_SPANS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic                 in_mode,
    input  logic [SPAN_BITS-1:0] in_first,
    input  logic [SPAN_BITS-1:0] in_last,
    input  logic [VW_BITS-1:0]   view_width,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [FRAG_BITS-1:0] m_frag_first,
    output logic [FRAG_BITS-1:0] m_frag_last,
    output logic                 m_frag_final
);

    localparam int IDX_W  = $clog2(MAX_SPANS);
    localparam int CNT_W  = $clog2(MAX_SPANS + 1);
    localparam int ADDR_W = IDX_W + 1;
    localparam int ENT_W  = 2 * COLUMN_BITS;
    localparam int EW     = (COLUMN_BITS + 2 > SPAN_BITS) ? COLUMN_BITS + 2 : SPAN_BITS;
    localparam int COL_MAX_I = (1 << (COLUMN_BITS - 1)) - 1;
    localparam int COL_MIN_I = -(1 << (COLUMN_BITS - 1));
    localparam int W_CAP_I   = (WIDTH_CAP < COL_MAX_I) ? WIDTH_CAP : COL_MAX_I;
    localparam int W_RST_I   = (VIEW_WIDTH_RESET < W_CAP_I) ? VIEW_WIDTH_RESET : W_CAP_I;

    localparam logic signed [EW-1:0] COL_MAX_E = EW'(COL_MAX_I);
    localparam logic signed [EW-1:0] COL_MIN_E = EW'(COL_MIN_I);
    localparam logic signed [EW-1:0] W_CAP_E   = EW'(W_CAP_I);
    localparam logic signed [EW-1:0] W_RST_E   = EW'(W_RST_I);
    localparam logic signed [EW-1:0] ONE_E     = EW'(1);
    localparam logic signed [EW-1:0] ZERO_E    = EW'(0);

    // item and merge registers
    logic signed [EW-1:0] f_reg, f_next, l_reg, l_next, w_reg, w_next;
    logic signed [EW-1:0] cur_start_reg, cur_start_next, end_n_reg, end_n_next;
    logic                 mode_reg, mode_next;
    merge_phase_t         phase_reg, phase_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next, wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0]     proc_idx_reg, proc_idx_next;
    logic                 bank_reg, bank_next;
    logic [RES_CNT_BITS-1:0] res_cnt_reg, res_cnt_next;

    // fragment holding and output registers
    logic                 pend_valid_reg, pend_valid_next;
    logic [FRAG_BITS-1:0] pend_first_reg, pend_first_next, pend_last_reg, pend_last_next;
    logic                 m_valid_reg, m_valid_next, m_final_reg, m_final_next;
    logic [FRAG_BITS-1:0] m_first_reg, m_first_next, m_last_reg, m_last_next;

    // memory
    logic                ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0]   ram_wr_addr, ram_rd_addr;
    logic [ENT_W-1:0]    ram_wr_data, ram_rd_data;

    // input conditioning
    logic signed [EW-1:0] in_first_e, in_last_e, sat_first, sat_last, vw_e, eff_w;

    // merge step
    logic signed [EW-1:0] e_st, e_en, st_m1, endn_p1, f_m1, w_m1;
    logic                 is_last, seek_hit;
    logic                 p_wr, p_emit, p_adv;
    logic signed [EW-1:0] p_ws, p_we, p_ea, p_eb;
    merge_phase_t         p_phase;
    logic signed [EW-1:0] p_cur_start, p_end_n;

    logic                 emit_raw;
    logic signed [EW-1:0] ea, eb, ca, cb;
    logic                 emit_ok, out_free, go, step_fire, tail_fire, fire_emit, flush_fire;
    logic                 out_load;
    logic [CNT_W-1:0]     proc_idx_inc;

    ssol_ram #(
        .WIDTH (ENT_W),
        .DEPTH (2 * MAX_SPANS)
    ) u_list_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // saturate span bounds and cap the view width
    always_comb begin
        in_first_e = EW'($signed(in_first));
        in_last_e  = EW'($signed(in_last));
        if (in_first_e < COL_MIN_E)      sat_first = COL_MIN_E;
        else if (in_first_e > COL_MAX_E) sat_first = COL_MAX_E;
        else                             sat_first = in_first_e;
        if (in_last_e < COL_MIN_E)       sat_last = COL_MIN_E;
        else if (in_last_e > COL_MAX_E)  sat_last = COL_MAX_E;
        else                             sat_last = in_last_e;
        vw_e  = EW'(view_width);
        eff_w = (vw_e > W_CAP_E) ? W_CAP_E : vw_e;
    end

    assign e_st    = EW'($signed(ram_rd_data[COLUMN_BITS-1:0]));
    assign e_en    = EW'($signed(ram_rd_data[ENT_W-1:COLUMN_BITS]));
    assign st_m1   = e_st - ONE_E;
    assign endn_p1 = end_n_reg + ONE_E;
    assign f_m1    = f_reg - ONE_E;
    assign w_m1    = w_reg - ONE_E;
    assign is_last = (proc_idx_reg == cnt_reg - CNT_W'(1));
    assign seek_hit = is_last || (e_en >= f_m1);
    assign proc_idx_inc = proc_idx_reg + CNT_W'(1);

    // at most one stored span per step
    always_comb begin
        p_wr        = 1'b0;
        p_emit      = 1'b0;
        p_adv       = 1'b0;
        p_ws        = e_st;
        p_we        = e_en;
        p_ea        = f_reg;
        p_eb        = l_reg;
        p_phase     = phase_reg;
        p_cur_start = cur_start_reg;
        p_end_n     = end_n_reg;
        unique case (phase_reg)
            PH_SEEK: begin
                if (!seek_hit) begin
                    p_wr  = 1'b1;
                    p_adv = 1'b1;
                end else if (f_reg < e_st && l_reg < st_m1) begin
                    p_emit  = 1'b1;
                    p_wr    = 1'b1;
                    p_phase = PH_COPY;
                    if (cnt_reg < CNT_W'(MAX_SPANS)) begin
                        p_ws = f_reg;
                        p_we = l_reg;
                    end else begin
                        p_adv = 1'b1;
                    end
                end else begin
                    if (f_reg < e_st) begin
                        p_emit      = 1'b1;
                        p_eb        = st_m1;
                        p_cur_start = f_reg;
                    end else begin
                        p_cur_start = e_st;
                    end
                    p_adv = 1'b1;
                    if (l_reg <= e_en) begin
                        p_wr    = 1'b1;
                        p_ws    = p_cur_start;
                        p_phase = PH_COPY;
                    end else begin
                        p_end_n = e_en;
                        p_phase = PH_MERGE;
                    end
                end
            end
            PH_MERGE: begin
                p_emit = 1'b1;
                p_ea   = endn_p1;
                if (l_reg >= st_m1) begin
                    p_eb  = st_m1;
                    p_adv = 1'b1;
                    if (l_reg <= e_en) begin
                        p_wr    = 1'b1;
                        p_ws    = cur_start_reg;
                        p_phase = PH_COPY;
                    end else begin
                        p_end_n = e_en;
                    end
                end else begin
                    p_eb    = l_reg;
                    p_wr    = 1'b1;
                    p_ws    = cur_start_reg;
                    p_we    = l_reg;
                    p_phase = PH_COPY;
                end
            end
            PH_COPY: begin
                p_wr  = 1'b1;
                p_adv = 1'b1;
            end
            default: p_phase = PH_SEEK;
        endcase
    end

    // clamp and output gating
    always_comb begin
        emit_raw = cmd.step ? p_emit : cmd.tail;
        ea       = cmd.step ? p_ea : endn_p1;
        eb       = cmd.step ? p_eb : l_reg;
        ca       = (ea < ZERO_E) ? ZERO_E : ea;
        cb       = (eb >= w_reg) ? w_m1 : eb;
        emit_ok  = emit_raw && (ca <= cb) && (res_cnt_reg < RES_CNT_BITS'(MAX_RESULTS));
        out_free = !m_valid_reg || m_tready;
        go       = !(emit_ok && pend_valid_reg && !out_free);
        step_fire  = cmd.step && go;
        tail_fire  = cmd.tail && go;
        fire_emit  = (step_fire || tail_fire) && emit_ok;
        flush_fire = cmd.flush && pend_valid_reg && out_free;
        out_load   = (fire_emit && pend_valid_reg) || flush_fire;
    end

    // list memory ports
    always_comb begin
        ram_wr_en   = (step_fire && p_wr) || tail_fire || cmd.clr_lo || cmd.clr_hi;
        ram_wr_addr = {!bank_reg, wr_idx_reg[IDX_W-1:0]};
        ram_wr_data = {p_we[COLUMN_BITS-1:0], p_ws[COLUMN_BITS-1:0]};
        if (cmd.tail) begin
            ram_wr_data = {l_reg[COLUMN_BITS-1:0], cur_start_reg[COLUMN_BITS-1:0]};
        end
        if (cmd.clr_lo) begin
            ram_wr_addr = {bank_reg, IDX_W'(0)};
            ram_wr_data = {COLUMN_BITS'(-1), COL_MIN_E[COLUMN_BITS-1:0]};
        end else if (cmd.clr_hi) begin
            ram_wr_addr = {bank_reg, IDX_W'(1)};
            ram_wr_data = {COL_MAX_E[COLUMN_BITS-1:0], w_reg[COLUMN_BITS-1:0]};
        end
        ram_rd_en   = cmd.prime || (step_fire && p_adv);
        ram_rd_addr = cmd.prime ? {bank_reg, IDX_W'(0)} : {bank_reg, proc_idx_inc[IDX_W-1:0]};
    end

    always_comb begin
        f_next          = f_reg;
        l_next          = l_reg;
        w_next          = w_reg;
        mode_next       = mode_reg;
        phase_next      = phase_reg;
        cur_start_next  = cur_start_reg;
        end_n_next      = end_n_reg;
        cnt_next        = cnt_reg;
        wr_idx_next     = wr_idx_reg;
        proc_idx_next   = proc_idx_reg;
        bank_next       = bank_reg;
        res_cnt_next    = res_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_first_next = pend_first_reg;
        pend_last_next  = pend_last_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_first_next    = m_first_reg;
        m_last_next     = m_last_reg;
        m_final_next    = m_final_reg;

        if (cmd.load) begin
            f_next        = sat_first;
            l_next        = sat_last;
            w_next        = eff_w;
            mode_next     = in_mode;
            phase_next    = PH_SEEK;
            wr_idx_next   = '0;
            proc_idx_next = '0;
            res_cnt_next  = '0;
        end
        if (cmd.clr_hi) begin
            cnt_next = CNT_W'(2);
        end
        if (step_fire) begin
            phase_next     = p_phase;
            cur_start_next = p_cur_start;
            end_n_next     = p_end_n;
            if (p_wr)  wr_idx_next   = wr_idx_reg + CNT_W'(1);
            if (p_adv) proc_idx_next = proc_idx_inc;
        end
        if (tail_fire) begin
            wr_idx_next = wr_idx_reg + CNT_W'(1);
            phase_next  = PH_COPY;
        end
        if (cmd.commit) begin
            cnt_next  = wr_idx_reg;
            bank_next = !bank_reg;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
            m_first_next = pend_first_reg;
            m_last_next  = pend_last_reg;
            m_final_next = flush_fire;
        end
        if (fire_emit) begin
            pend_valid_next = 1'b1;
            pend_first_next = ca[FRAG_BITS-1:0];
            pend_last_next  = cb[FRAG_BITS-1:0];
            res_cnt_next    = res_cnt_reg + RES_CNT_BITS'(1);
        end else if (flush_fire) begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg          <= W_RST_E;
            phase_reg      <= PH_SEEK;
            cnt_reg        <= CNT_W'(2);
            wr_idx_reg     <= '0;
            proc_idx_reg   <= '0;
            bank_reg       <= 1'b0;
            res_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            w_reg          <= w_next;
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            wr_idx_reg     <= wr_idx_next;
            proc_idx_reg   <= proc_idx_next;
            bank_reg       <= bank_next;
            res_cnt_reg    <= res_cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        f_reg          <= f_next;
        l_reg          <= l_next;
        mode_reg       <= mode_next;
        cur_start_reg  <= cur_start_next;
        end_n_reg      <= end_n_next;
        pend_first_reg <= pend_first_next;
        pend_last_reg  <= pend_last_next;
        m_first_reg    <= m_first_next;
        m_last_reg     <= m_last_next;
        m_final_reg    <= m_final_next;
    end

    always_comb begin
        stat.is_clear  = (mode_reg == MODE_CLEAR);
        stat.ignore    = (f_reg > l_reg);
        stat.go        = go;
        stat.pass_end  = step_fire && p_adv && is_last;
        stat.need_tail = (p_phase == PH_MERGE);
        stat.flush_ok  = !pend_valid_reg || out_free;
    end

    assign m_tvalid     = m_valid_reg;
    assign m_frag_first = m_first_reg;
    assign m_frag_last  = m_last_reg;
    assign m_frag_final = m_final_reg;

endmodule

@@ rtl/solid_span_occlusion_list.sv @@
// Top level of the solid span occlusion list: ports, view width register, sequencer and datapath.
//
//  channel  | direction | transfer contents
//  s_       | in        | tuser: mode; tdata: span_first, span_last
//  m_       | out       | tdata: frag_first, frag_last; tlast: frag_final
//  apb      | in/out    | view_width at byte address 0
//
// An insert makes one merge pass over the stored spans, reading at most one stored span from
// the list memory per cycle while the m_ channel does not stall, then commits and flushes.
// An inverted span returns to idle from ST_DISPATCH, and a clear rewrites both sentinels.
// After reset the sentinels are written in ST_CLR_LO and ST_CLR_HI before s_tready rises.
// A stalled m_ channel holds the pass whenever a fragment cannot move on.
module solid_span_occlusion_list import ssol_pkg::*; #(
    parameter int MAX_SPANS   = MAX_SPANS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [S_TDATA_BITS-1:0]  s_tdata,   // [13:0] span_first, [27:14] span_last
    input  logic                     s_tuser,   // [0] mode
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [M_TDATA_BITS-1:0]  m_tdata,   // [11:0] frag_first, [23:12] frag_last
    output logic                     m_tlast,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    logic [VW_BITS-1:0]   view_width_reg, view_width_next;
    logic                 cfg_wr;
    dp_cmd_t              cmd;
    dp_stat_t             stat;
    logic [FRAG_BITS-1:0] frag_first, frag_last;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_VIEW_WIDTH);
    assign view_width_next = cfg_wr ? pwdata[VW_BITS-1:0] : view_width_reg;
    assign prdata = (paddr[2] == REG_VIEW_WIDTH) ? APB_DATA_BITS'(view_width_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            view_width_reg <= VW_BITS'(VIEW_WIDTH_RESET);
        end else begin
            view_width_reg <= view_width_next;
        end
    end

    ssol_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ssol_dp #(
        .MAX_SPANS   (MAX_SPANS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .in_mode      (s_tuser),
        .in_first     (s_tdata[SPAN_BITS-1:0]),
        .in_last      (s_tdata[2*SPAN_BITS-1:SPAN_BITS]),
        .view_width   (view_width_reg),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_frag_first (frag_first),
        .m_frag_last  (frag_last),
        .m_frag_final (m_tlast)
    );

    assign m_tdata = {frag_last, frag_first};

endmodule

@@ verif/solid_span_occlusion_list_tb.sv @@
// Self-checking testbench for the solid span occlusion list: stream stimulus, APB setup, fragment checks.
`timescale 1ns / 1ps

module solid_span_occlusion_list_tb;
    import ssol_pkg::*;

    localparam int COL_MAX     = (1 << (SPAN_BITS - 1)) - 1;
    localparam int COL_MIN     = -(1 << (SPAN_BITS - 1));
    localparam int SETTLE      = 100;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEM_TARGET = 350;

    typedef struct packed {
        logic [FRAG_BITS-1:0] col_first;
        logic [FRAG_BITS-1:0] col_last;
        logic                 is_last;
    } frag_t;

    logic                     aclk     = 1'b0;
    logic                     aresetn  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [S_TDATA_BITS-1:0]  s_tdata  = '0;
    logic                     s_tuser  = MODE_CLEAR;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0]  m_tdata;
    logic                     m_tlast;
    logic                     psel     = 1'b0;
    logic                     penable  = 1'b0;
    logic                     pwrite   = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr    = '0;
    logic [APB_DATA_BITS-1:0] pwdata   = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    // model state
    logic [VW_BITS-1:0]          view_width_reg;
    logic signed [SPAN_BITS-1:0] cover_lo [MAX_SPANS_DEF];
    logic signed [SPAN_BITS-1:0] cover_hi [MAX_SPANS_DEF];
    int                          cover_cnt;

    frag_t item_frags[$];
    frag_t visible_frags[$];

    int  err_count   = 0;
    int  cycle_count = 0;
    int  item_count  = 0;
    bit  quiet       = 1'b0;
    int  stall_left  = 0;

    solid_span_occlusion_list uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        err_count++;
    endtask

    // ---------------- prediction ----------------

    function automatic int active_width();
        int w;
        w = int'(view_width_reg);
        if (w > WIDTH_CAP) w = WIDTH_CAP;
        if (w > COL_MAX) w = COL_MAX;
        return w;
    endfunction

    function automatic void reset_sentinels();
        cover_lo[0] = SPAN_BITS'(COL_MIN);
        cover_hi[0] = SPAN_BITS'(-1);
        cover_lo[1] = SPAN_BITS'(active_width());
        cover_hi[1] = SPAN_BITS'(COL_MAX);
        cover_cnt   = 2;
    endfunction

    function automatic void add_frag(input int a, input int b);
        int w;
        w = active_width();
        if (a < 0) a = 0;
        if (b >= w) b = w - 1;
        if (a > b || item_frags.size() >= MAX_RESULTS) return;
        item_frags.push_back('{FRAG_BITS'(a), FRAG_BITS'(b), 1'b0});
    endfunction

    function automatic void occlude_span(input int first, input int last);
        int s, n, cnt, gone, i;
        bit joined;
        s = 0;
        cnt = cover_cnt;
        joined = 1'b0;
        while (s < cnt - 1 && int'(cover_hi[s]) < first - 1) s++;
        if (first < int'(cover_lo[s])) begin
            if (last < int'(cover_lo[s]) - 1) begin
                add_frag(first, last);
                if (cnt < MAX_SPANS_DEF) begin
                    for (i = cnt; i > s; i--) begin
                        cover_lo[i] = cover_lo[i-1];
                        cover_hi[i] = cover_hi[i-1];
                    end
                    cover_lo[s] = SPAN_BITS'(first);
                    cover_hi[s] = SPAN_BITS'(last);
                    cover_cnt = cnt + 1;
                end
                return;
            end
            add_frag(first, int'(cover_lo[s]) - 1);
            cover_lo[s] = SPAN_BITS'(first);
        end
        if (last <= int'(cover_hi[s])) return;
        n = s;
        while (!joined && n + 1 < cnt && last >= int'(cover_lo[n+1]) - 1) begin
            add_frag(int'(cover_hi[n]) + 1, int'(cover_lo[n+1]) - 1);
            n++;
            if (last <= int'(cover_hi[n])) begin
                cover_hi[s] = cover_hi[n];
                joined = 1'b1;
            end
        end
        if (!joined) begin
            add_frag(int'(cover_hi[n]) + 1, last);
            cover_hi[s] = SPAN_BITS'(last);
        end
        if (n == s) return;
        gone = n - s;
        for (i = n + 1; i < cnt; i++) begin
            cover_lo[i-gone] = cover_lo[i];
            cover_hi[i-gone] = cover_hi[i];
        end
        cover_cnt = cnt - gone;
    endfunction

    function automatic void predict_fragments(input logic mode,
                                              input logic signed [SPAN_BITS-1:0] f,
                                              input logic signed [SPAN_BITS-1:0] l);
        if (mode == MODE_CLEAR) begin
            reset_sentinels();
            return;
        end
        if (f > l) return;
        item_frags.delete();
        occlude_span(int'(f), int'(l));
        if (item_frags.size() > 0) item_frags[$].is_last = 1'b1;
        foreach (item_frags[k]) visible_frags.push_back(item_frags[k]);
    endfunction

    // ---------------- checking ----------------

    always @(posedge aclk) begin
        frag_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (visible_frags.size() == 0) begin
                report_mismatch($sformatf("unexpected fragment %0d..%0d",
                                          m_tdata[FRAG_BITS-1:0], m_tdata[2*FRAG_BITS-1:FRAG_BITS]));
            end else begin
                want = visible_frags.pop_front();
                if (m_tdata[FRAG_BITS-1:0] != want.col_first)
                    report_mismatch($sformatf("frag_first %0d, want %0d",
                                              m_tdata[FRAG_BITS-1:0], want.col_first));
                if (m_tdata[2*FRAG_BITS-1:FRAG_BITS] != want.col_last)
                    report_mismatch($sformatf("frag_last %0d, want %0d",
                                              m_tdata[2*FRAG_BITS-1:FRAG_BITS], want.col_last));
                if (m_tlast != want.is_last)
                    report_mismatch($sformatf("frag_final %0b, want %0b",
                                              m_tlast, want.is_last));
            end
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------- drivers ----------------

    task automatic send_item(input logic mode, input int first, input int last);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(S_TDATA_BITS-2*SPAN_BITS){1'b0}},
                     last[SPAN_BITS-1:0], first[SPAN_BITS-1:0]};
        do @(posedge aclk); while (!s_tready);
        item_count++;
        predict_fragments(mode, first[SPAN_BITS-1:0], last[SPAN_BITS-1:0]);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (visible_frags.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_view_width(input int value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_BITS'(4 * REG_VIEW_WIDTH);
        pwdata  <= APB_DATA_BITS'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        view_width_reg = VW_BITS'(value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[VW_BITS-1:0] != view_width_reg)
            report_mismatch($sformatf("view_width reads %0d, want %0d",
                                      prdata[VW_BITS-1:0], view_width_reg));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_width();
        send_item(MODE_INSERT, 0, 319);
        send_item(MODE_INSERT, 100, 200);
        send_item(MODE_CLEAR, 0, 0);
        send_item(MODE_INSERT, -1, 4096);
        send_item(MODE_CLEAR, 0, 0);
    endtask

    task automatic test_field_extremes();
        send_item(MODE_INSERT, COL_MIN, COL_MAX);
        send_item(MODE_CLEAR, COL_MAX, COL_MIN);
        send_item(MODE_INSERT, COL_MAX, COL_MIN);
        send_item(MODE_INSERT, 5, 4);
        send_item(MODE_INSERT, COL_MIN, -1);
        send_item(MODE_INSERT, 320, COL_MAX);
        send_item(MODE_INSERT, COL_MIN, COL_MIN);
    endtask

    task automatic test_merging();
        write_view_width(64);
        send_item(MODE_CLEAR, 0, 0);
        send_item(MODE_INSERT, 10, 12);
        send_item(MODE_INSERT, 20, 22);
        send_item(MODE_INSERT, 13, 19);
        send_item(MODE_INSERT, 30, 30);
        send_item(MODE_INSERT, 40, 45);
        send_item(MODE_INSERT, 5, 50);
        send_item(MODE_INSERT, 8, 8);
        send_item(MODE_INSERT, 62, 70);
        send_item(MODE_INSERT, -3, 2);
    endtask

    task automatic test_width_change();
        write_view_width(16);
        send_item(MODE_INSERT, 0, 63);
        send_item(MODE_CLEAR, 0, 0);
        send_item(MODE_INSERT, 0, 63);
        write_view_width(WIDTH_CAP);
        send_item(MODE_CLEAR, 0, 0);
        send_item(MODE_INSERT, 0, COL_MAX);
        write_view_width(1);
        send_item(MODE_CLEAR, 0, 0);
        send_item(MODE_INSERT, -1, 1);
    endtask

    task automatic test_list_full();
        int cols[34];
        int j, tmp;
        foreach (cols[k]) cols[k] = 2 * k;
        for (int k = 33; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = cols[k];
            cols[k] = cols[j];
            cols[j] = tmp;
        end
        write_view_width(128);
        send_item(MODE_CLEAR, 0, 0);
        foreach (cols[k]) send_item(MODE_INSERT, cols[k], cols[k]);
        send_item(MODE_INSERT, 0, 127);
        send_item(MODE_CLEAR, 0, 0);
    endtask

    task automatic pick_span(input int w, output int first, output int last);
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            first = $urandom_range(0, w + 3) - 2;
            last  = first + $urandom_range(0, (w < 32) ? 3 : w / 8);
        end else if (kind < 75) begin
            first = $urandom_range(0, w + 3) - 2;
            last  = first + $urandom_range(0, w + 4);
        end else if (kind < 90) begin
            first = $urandom_range(0, 16383);
            last  = $urandom_range(0, 16383);
            if (first > COL_MAX) first -= 16384;
            if (last > COL_MAX) last -= 16384;
        end else begin
            first = $urandom_range(1, w + 2);
            last  = first - $urandom_range(1, 5);
        end
        if (last > COL_MAX) last = COL_MAX;
    endtask

    task automatic test_random_frames();
        int phase, w, first, last;
        phase = 0;
        while (item_count < ITEM_TARGET) begin
            case (phase)
                0: w = 1;
                1: w = WIDTH_CAP;
                default: begin
                    w = $urandom_range(0, 9);
                    if (w < 7) w = $urandom_range(8, 96);
                    else if (w < 9) w = $urandom_range(97, WIDTH_CAP);
                    else w = VIEW_WIDTH_RESET;
                end
            endcase
            write_view_width(w);
            repeat ($urandom_range(2, 4)) begin
                if (item_count < ITEM_TARGET && $urandom_range(0, 9) >= 3)
                    send_item(MODE_CLEAR, $urandom_range(0, 16383), $urandom_range(0, 16383));
                repeat ($urandom_range(4, 40)) begin
                    if (item_count < ITEM_TARGET) begin
                        pick_span(w, first, last);
                        send_item(MODE_INSERT, first, last);
                    end
                    if (item_count >= ITEM_TARGET - 50) quiet = 1'b1;
                end
            end
            phase++;
        end
    endtask

    initial begin
        view_width_reg = VW_BITS'(VIEW_WIDTH_RESET);
        foreach (cover_lo[k]) begin
            cover_lo[k] = '0;
            cover_hi[k] = '0;
        end
        reset_sentinels();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_width();
        test_field_extremes();
        test_merging();
        test_width_change();
        test_list_full();
        test_random_frames();

        drain();
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ssol_pkg.sv
rtl/ssol_ram.sv
rtl/ssol_ctrl.sv
rtl/ssol_dp.sv
rtl/solid_span_occlusion_list.sv
verif/solid_span_occlusion_list_tb.sv
